>>> rtl/srns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srns_pkg
// Shared types, constants and arithmetic helpers of the recurrent net step.
// ----------------------------------------------------------------------------
package srns_pkg;

  localparam int DEF_MAX_NODES  = 16;
  localparam int DEF_MAX_FANOUT = 8;

  localparam int Q_W      = 32;
  localparam int OP_W     = 2;
  localparam int IDX_W    = 4;
  localparam int SLOT_W   = 3;
  localparam int FAN_W    = 4;
  localparam int NCOUNT_W = 5;

  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 5'd2;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh80000000;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_NODE = 2'd0,
    OP_LOAD_CONN = 2'd1,
    OP_RESET_MEM = 2'd2,
    OP_STEP      = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LATCH,
    DP_LOAD_NODE,
    DP_LOAD_CONN,
    DP_RS_RD,
    DP_RS_WR,
    DP_N0_RD,
    DP_N0_WR,
    DP_FS_CLR,
    DP_ND_RD,
    DP_ND_CHK,
    DP_CN_RD,
    DP_CN_MUL,
    DP_CN_FS,
    DP_CN_ACC,
    DP_FIN_RD,
    DP_FIN_WR,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   i_clr;
    logic   i_inc;
  } dp_cmd_t;

  typedef struct packed {
    op_t  item_op;
    logic clr_done;
    logic i_last;
    logic prev_act;
    logic j_done;
    logic conn_ok;
  } dp_status_t;

  function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) begin
      sat_add = s[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      sat_add = s[Q_W-1:0];
    end
  endfunction

  function automatic logic signed [Q_W-1:0] sat_prod(input logic signed [2*Q_W-1:0] p);
    logic signed [2*Q_W-17:0] sh;
    sh = p[2*Q_W-1:16];
    if (sh > 48'sh00007fffffff) begin
      sat_prod = Q_MAX;
    end else if (sh < -48'sh000080000000) begin
      sat_prod = Q_MIN;
    end else begin
      sat_prod = sh[Q_W-1:0];
    end
  endfunction

endpackage

>>> rtl/srns_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srns_ctrl
// Sequencer of the recurrent net step: clearing pass, loads, resets, steps.
// ----------------------------------------------------------------------------
module srns_ctrl
  import srns_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD_NODE, S_LOAD_CONN, S_RS_RD, S_RS_WR, S_N0_RD, S_N0_WR,
    S_FS_CLR, S_ND_RD, S_ND_CHK, S_CN_RD, S_CN_MUL, S_CN_FS, S_CN_ACC, S_FIN_RD,
    S_FIN_WR, S_DONE
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    cmd.i_clr  = 1'b0;
    cmd.i_inc  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (status.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LATCH;
          state_next = S_LOAD_NODE;
        end
      end
      S_LOAD_NODE: begin
        case (status.item_op)
          OP_LOAD_NODE: begin
            cmd.op = DP_LOAD_NODE;
            state_next = S_DONE;
          end
          OP_LOAD_CONN: state_next = S_LOAD_CONN;
          OP_RESET_MEM: state_next = S_RS_RD;
          default:      state_next = S_N0_RD;
        endcase
      end
      S_LOAD_CONN: begin
        cmd.op = DP_LOAD_CONN;
        state_next = S_DONE;
      end
      S_RS_RD: begin
        cmd.op = DP_RS_RD;
        state_next = S_RS_WR;
      end
      S_RS_WR: begin
        cmd.op = DP_RS_WR;
        cmd.i_inc = 1'b1;
        state_next = status.i_last ? S_DONE : S_RS_RD;
      end
      S_N0_RD: begin
        cmd.op = DP_N0_RD;
        state_next = S_N0_WR;
      end
      S_N0_WR: begin
        cmd.op = DP_N0_WR;
        state_next = S_FS_CLR;
      end
      S_FS_CLR: begin
        cmd.op = DP_FS_CLR;
        if (status.i_last) begin
          cmd.i_clr = 1'b1;
          state_next = S_ND_RD;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_ND_RD: begin
        cmd.op = DP_ND_RD;
        state_next = S_ND_CHK;
      end
      S_ND_CHK: begin
        cmd.op = DP_ND_CHK;
        if (status.prev_act) begin
          state_next = S_CN_RD;
        end else if (status.i_last) begin
          cmd.i_clr = 1'b1;
          state_next = S_FIN_RD;
        end else begin
          cmd.i_inc = 1'b1;
          state_next = S_ND_RD;
        end
      end
      S_CN_RD: begin
        cmd.op = DP_CN_RD;
        if (!status.j_done) begin
          state_next = S_CN_MUL;
        end else if (status.i_last) begin
          cmd.i_clr = 1'b1;
          state_next = S_FIN_RD;
        end else begin
          cmd.i_inc = 1'b1;
          state_next = S_ND_RD;
        end
      end
      S_CN_MUL: begin
        cmd.op = DP_CN_MUL;
        state_next = S_CN_FS;
      end
      S_CN_FS: begin
        cmd.op = DP_CN_FS;
        state_next = status.conn_ok ? S_CN_ACC : S_CN_RD;
      end
      S_CN_ACC: begin
        cmd.op = DP_CN_ACC;
        state_next = S_CN_RD;
      end
      S_FIN_RD: begin
        cmd.op = DP_FIN_RD;
        state_next = S_FIN_WR;
      end
      S_FIN_WR: begin
        cmd.op = DP_FIN_WR;
        cmd.i_inc = 1'b1;
        state_next = status.i_last ? S_DONE : S_FIN_RD;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op = DP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    state != S_CLEAR |=> state != S_CLEAR) else $error("clearing pass restarted");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> state != S_IDLE) else $error("transfer not taken");
  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> state == S_DONE)
    else $error("result overwrote a stalled transfer");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("result without an item");

endmodule

>>> rtl/srns_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srns_dp
// Datapath of the recurrent net step: node and connection stores,
// accumulators, multiplier and saturating adders.
// ----------------------------------------------------------------------------
module srns_dp
  import srns_pkg::*;
#(
  parameter int MAX_NODES  = DEF_MAX_NODES,
  parameter int MAX_FANOUT = DEF_MAX_FANOUT,
  parameter int CNT_W      = $clog2(MAX_NODES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  logic [CNT_W-1:0]        n_use,
  input  logic [OP_W-1:0]         operation,
  input  logic [IDX_W-1:0]        node_index,
  input  logic [SLOT_W-1:0]       slot,
  input  logic [IDX_W-1:0]        target_node,
  input  logic signed [Q_W-1:0]   value,
  input  logic signed [Q_W-1:0]   default_value,
  input  logic [FAN_W-1:0]        fanout,
  output logic signed [Q_W-1:0]   output_value,
  output logic                    output_active
);

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CONN_DEPTH = MAX_NODES * MAX_FANOUT;
  localparam int CONN_AW    = (CONN_DEPTH > 1) ? $clog2(CONN_DEPTH) : 1;

  op_t                   op_r;
  logic [IDX_W-1:0]      nidx_r, tgt_r;
  logic [SLOT_W-1:0]     slot_r;
  logic signed [Q_W-1:0] val_r, dval_r;
  logic [FAN_W-1:0]      fan_r;

  logic [CNT_W-1:0]   i_cnt;
  logic [FAN_W-1:0]   j_cnt;
  logic [CONN_AW-1:0] clr_cnt;
  logic [NODE_W-1:0]  i_idx, t_idx, clr_nidx, ld_nidx, mem_ra, fs_ra;
  logic [CONN_AW-1:0] walk_addr, ld_addr;
  logic               clr_node, ld_node_ok, ld_conn_ok;

  logic signed [Q_W-1:0]   mem_q [MAX_NODES];
  logic signed [Q_W-1:0]   bias_q [MAX_NODES];
  logic signed [Q_W-1:0]   dflt_q [MAX_NODES];
  logic [FAN_W-1:0]        fan_q [MAX_NODES];
  logic signed [Q_W-1:0]   fs_q [MAX_NODES];
  logic signed [Q_W-1:0]   w_q [CONN_DEPTH];
  logic [IDX_W-1:0]        t_q [CONN_DEPTH];

  logic signed [Q_W-1:0]   mem_rd, bias_rd, dflt_rd, fs_rd, w_rd;
  logic [FAN_W-1:0]        fan_rd;
  logic [IDX_W-1:0]        t_rd;

  logic [MAX_NODES-1:0]    act, prev;
  logic signed [Q_W-1:0]   memi, qv, q_c, fin_v, res_val;
  logic [FAN_W-1:0]        fanr;
  logic [IDX_W-1:0]        tq;
  logic signed [2*Q_W-1:0] prod;
  logic                    res_act;

  assign i_idx      = i_cnt[NODE_W-1:0];
  assign t_idx      = NODE_W'(tq);
  assign clr_nidx   = NODE_W'(clr_cnt);
  assign ld_nidx    = NODE_W'(nidx_r);
  assign clr_node   = 32'(clr_cnt) < MAX_NODES;
  assign ld_node_ok = 32'(nidx_r) < MAX_NODES;
  assign ld_conn_ok = ld_node_ok && (32'(slot_r) < MAX_FANOUT);
  assign walk_addr  = CONN_AW'(32'(i_cnt) * MAX_FANOUT + 32'(j_cnt));
  assign ld_addr    = CONN_AW'(32'(nidx_r) * MAX_FANOUT + 32'(slot_r));
  assign mem_ra     = (cmd.op == DP_N0_RD) ? {NODE_W{1'b0}} : i_idx;
  assign fs_ra      = (cmd.op == DP_CN_FS) ? t_idx : i_idx;
  assign q_c        = sat_prod(prod);
  assign fin_v      = act[i_idx] ? sat_add(fs_rd, bias_rd) : fs_rd;

  assign status.item_op  = op_r;
  assign status.clr_done = 32'(clr_cnt) == CONN_DEPTH - 1;
  assign status.i_last   = i_cnt == n_use - CNT_W'(1);
  assign status.prev_act = prev[i_idx];
  assign status.j_done   = j_cnt >= fanr;
  assign status.conn_ok  = !q_c[Q_W-1] && (32'(tq) < 32'(n_use));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      i_cnt   <= '0;
      j_cnt   <= '0;
      act     <= '1;
    end else begin
      if (cmd.op == DP_CLEAR && !status.clr_done) clr_cnt <= clr_cnt + CONN_AW'(1);
      if (cmd.op == DP_LATCH || cmd.i_clr) begin
        i_cnt <= '0;
      end else if (cmd.i_inc) begin
        i_cnt <= i_cnt + CNT_W'(1);
      end
      if (cmd.op == DP_ND_RD) begin
        j_cnt <= '0;
      end else if ((cmd.op == DP_CN_FS && !status.conn_ok) || cmd.op == DP_CN_ACC) begin
        j_cnt <= j_cnt + FAN_W'(1);
      end
      if (cmd.op == DP_RS_WR) act[i_idx] <= 1'b1;
      if (cmd.op == DP_CN_ACC) act[t_idx] <= 1'b1;
      if (cmd.op == DP_N0_WR) begin
        for (int k = 0; k < MAX_NODES; k++) begin
          if (k < 32'(n_use)) act[k] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LATCH) begin
      op_r    <= op_t'(operation);
      nidx_r  <= node_index;
      slot_r  <= slot;
      tgt_r   <= target_node;
      val_r   <= value;
      dval_r  <= default_value;
      fan_r   <= (32'(fanout) > MAX_FANOUT) ? FAN_W'(MAX_FANOUT) : fanout;
      res_val <= '0;
      res_act <= 1'b0;
    end
    if (cmd.op == DP_N0_WR) begin
      for (int k = 0; k < MAX_NODES; k++) begin
        if (k < 32'(n_use)) prev[k] <= act[k];
      end
    end
    if (cmd.op == DP_ND_CHK) begin
      memi <= mem_rd;
      fanr <= fan_rd;
    end
    if (cmd.op == DP_CN_MUL) begin
      prod <= memi * w_rd;
      tq   <= t_rd;
    end
    if (cmd.op == DP_CN_FS) qv <= q_c;
    if (cmd.op == DP_FIN_WR && i_cnt == CNT_W'(1)) begin
      res_val <= act[i_idx] ? fin_v : '0;
      res_act <= act[i_idx];
    end
    if (cmd.op == DP_OUT) begin
      output_value  <= res_val;
      output_active <= res_act;
    end
  end

  always_ff @(posedge clk) begin
    mem_rd  <= mem_q[mem_ra];
    bias_rd <= bias_q[i_idx];
    dflt_rd <= dflt_q[i_idx];
    fan_rd  <= fan_q[i_idx];
    if (cmd.op == DP_CLEAR && clr_node) begin
      mem_q[clr_nidx]  <= '0;
      bias_q[clr_nidx] <= '0;
      dflt_q[clr_nidx] <= '0;
      fan_q[clr_nidx]  <= '0;
    end else if (cmd.op == DP_LOAD_NODE && ld_node_ok) begin
      bias_q[ld_nidx] <= val_r;
      dflt_q[ld_nidx] <= dval_r;
      fan_q[ld_nidx]  <= fan_r;
    end else if (cmd.op == DP_N0_WR) begin
      mem_q[{NODE_W{1'b0}}] <= sat_add(mem_rd, val_r);
    end else if (cmd.op == DP_RS_WR) begin
      mem_q[i_idx] <= dflt_rd;
    end else if (cmd.op == DP_FIN_WR) begin
      mem_q[i_idx] <= fin_v;
    end
  end

  always_ff @(posedge clk) begin
    fs_rd <= fs_q[fs_ra];
    if (cmd.op == DP_FS_CLR) begin
      fs_q[i_idx] <= '0;
    end else if (cmd.op == DP_CN_ACC) begin
      fs_q[t_idx] <= sat_add(fs_rd, qv);
    end
  end

  always_ff @(posedge clk) begin
    w_rd <= w_q[walk_addr];
    t_rd <= t_q[walk_addr];
    if (cmd.op == DP_CLEAR) begin
      w_q[clr_cnt] <= '0;
      t_q[clr_cnt] <= '0;
    end else if (cmd.op == DP_LOAD_CONN && ld_conn_ok) begin
      w_q[ld_addr] <= val_r;
      t_q[ld_addr] <= tgt_r;
    end
  end

endmodule

>>> rtl/sparse_recurrent_net_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_recurrent_net_step_core
// Small recurrent network of Q16.16 nodes with sparse weighted connections.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (in_valid / in_stall) and each one
// produces exactly one transfer on the output channel (out_valid /
// out_stall). One item is worked on at a time, by a sequencer over node and
// connection stores with one read and one write port each and registered reads.
// A memory reset walks the N nodes in use, and a step walks the N nodes and the
// connections of each active node, where N is the node count in use; the
// connection walk, one multiply and one read-modify-write of an accumulator per
// connection, sets the length of a step.
// The node_count register is to be written through the APB port only while idle;
// the block does not enforce it. After reset a clearing pass zeroes the stores;
// the input stays stalled meanwhile, register writes are taken.
// When the receiver stalls, the finished result holds in the output
// register; a new item may already be accepted, and its result waits.
// ----------------------------------------------------------------------------
module sparse_recurrent_net_step_core
  import srns_pkg::*;
#(
  parameter int MAX_NODES  = DEF_MAX_NODES,
  parameter int MAX_FANOUT = DEF_MAX_FANOUT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       operation,
  input  logic [IDX_W-1:0]      node_index,
  input  logic [SLOT_W-1:0]     slot,
  input  logic [IDX_W-1:0]      target_node,
  input  logic signed [Q_W-1:0] value,
  input  logic signed [Q_W-1:0] default_value,
  input  logic [FAN_W-1:0]      fanout,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [Q_W-1:0] output_value,
  output logic                  output_active,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);

  logic [NCOUNT_W-1:0] node_count;
  logic [CNT_W-1:0]    n_use;
  dp_cmd_t             cmd;
  dp_status_t          status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - NCOUNT_W){1'b0}}, node_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      node_count <= pwdata[NCOUNT_W-1:0];
    end
  end

  always_comb begin
    if (32'(node_count) < 2) begin
      n_use = CNT_W'(2);
    end else if (32'(node_count) > MAX_NODES) begin
      n_use = CNT_W'(MAX_NODES);
    end else begin
      n_use = CNT_W'(node_count);
    end
  end

  srns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  srns_dp #(
    .MAX_NODES  (MAX_NODES),
    .MAX_FANOUT (MAX_FANOUT),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .n_use         (n_use),
    .operation     (operation),
    .node_index    (node_index),
    .slot          (slot),
    .target_node   (target_node),
    .value         (value),
    .default_value (default_value),
    .fanout        (fanout),
    .output_value  (output_value),
    .output_active (output_active)
  );

endmodule
